>>> src/eur_pkg.sv
`default_nettype none

package eur_pkg;

    // Pulse counter width; the distance datapath widths follow from it.
    localparam int PULSE_COUNT_BITS = 17;

    // pulse * 17 fits in PULSE_COUNT_BITS + 5 bits.
    localparam int PROD_BITS  = PULSE_COUNT_BITS + 5;
    // Divide by 100 as a shift by two and then a divide by 25.
    localparam int QUART_BITS = PROD_BITS - 2;
    localparam int RECIP_SHIFT = QUART_BITS + 5;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'd24) / 64'd25;
    localparam int RECIP_BITS = RECIP_SHIFT - 4;
    localparam int RECIP_PROD_BITS = QUART_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] DIST_RECIP = RECIP_BITS'(RECIP_FULL);
    localparam logic [PROD_BITS-1:0] DIST_MUL = PROD_BITS'(17);

    localparam logic [15:0] TRIG_LOW_TICKS = 16'd2;

    localparam logic [PULSE_COUNT_BITS-1:0] PULSE_MAX = '1;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 8;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIGGER_WIDTH = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT       = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_DISTANCE  = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_DISTANCE  = 8'd3;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_TIMEOUT = 1'b1;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_TRIG_LOW  = 5'b00010,
        PH_TRIG_HIGH = 5'b00100,
        PH_WAIT      = 5'b01000,
        PH_MEASURE   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic start_req;
        logic echo_level;
    } in_word_t;

    typedef struct packed {
        logic        trigger_level;
        logic        busy_res;
        logic        done_res;
        logic        status;
        logic [15:0] range_mm;
    } out_word_t;

    typedef struct packed {
        logic [7:0]  trigger_width_us;
        logic [15:0] timeout_us;
        logic [15:0] min_range_mm;
        logic [15:0] max_range_mm;
    } cfg_t;

endpackage

`default_nettype wire

>>> src/ultrasonic_echo_ranger_unit.sv
// Channel  Direction  Handshake          Word
// in       input      in_valid/in_stall  in_word    (start_req, echo_level)
// out      output     out_valid/out_stall out_word  (trigger, busy, done, status, distance)
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One word in per cycle while in_stall is low, one word out per word in; a word passes
// through the input register and then the result register around the per-tick update.
// Reset (rst_n low, asynchronous) restores register defaults and goes idle.
// A stalled output holds its word; the input register then fills and in_stall rises.
// cfg_ready is always high; writes take effect on the next tick.
`default_nettype none

module ultrasonic_echo_ranger_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output      logic                               in_stall,
    input  wire eur_pkg::in_word_t                  in_word,
    output      logic                               out_valid,
    input  wire logic                               out_stall,
    output eur_pkg::out_word_t                      out_word,
    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [eur_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [15:0]                        cfg_data
);

    eur_pkg::cfg_t      cfg;
    eur_pkg::in_word_t  in_word_reg;
    logic               in_valid_reg;
    eur_pkg::out_word_t out_word_reg;
    logic               out_valid_reg;
    eur_pkg::out_word_t result;
    logic               advance;
    logic               accept;

    assign cfg_ready = 1'b1;

    eur_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // advance the held word when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    eur_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_word_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg <= in_word;
        end
        if (advance)
        begin
            out_word_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.done_res |-> out_word.busy_res)
        else $error("done without busy");

    a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.trigger_level |-> out_word.busy_res && !out_word.done_res)
        else $error("trigger outside a measurement");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room downstream");

    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("stepped word lost");

endmodule

`default_nettype wire

>>> src/eur_cfg_regs.sv
`default_nettype none

module eur_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_en,
    input  wire logic [eur_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  wire logic [15:0]                        wr_data,
    output eur_pkg::cfg_t                           cfg
);

    eur_pkg::cfg_t cfg_reg;
    eur_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                eur_pkg::CFG_TRIGGER_WIDTH: cfg_next.trigger_width_us = wr_data[7:0];
                eur_pkg::CFG_TIMEOUT:       cfg_next.timeout_us       = wr_data;
                eur_pkg::CFG_MIN_DISTANCE:  cfg_next.min_range_mm     = wr_data;
                eur_pkg::CFG_MAX_DISTANCE:  cfg_next.max_range_mm     = wr_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_width_us <= 8'd12;
            cfg_reg.timeout_us       <= 16'd30000;
            cfg_reg.min_range_mm     <= 16'd20;
            cfg_reg.max_range_mm     <= 16'd4000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> src/eur_core.sv
`default_nettype none

module eur_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire eur_pkg::in_word_t item,
    input  wire eur_pkg::cfg_t    cfg,
    output eur_pkg::out_word_t    result
);

    eur_pkg::phase_t phase_reg, phase_next;
    logic [15:0]     cnt_reg, cnt_next;
    logic [eur_pkg::PULSE_COUNT_BITS-1:0] pulse_reg, pulse_next;
    logic [15:0]     dist_reg, dist_next;
    logic            stat_reg, stat_next;

    logic [15:0]                          width;
    logic [15:0]                          cnt_inc;
    logic [eur_pkg::PROD_BITS-1:0]        prod;
    logic [eur_pkg::QUART_BITS-1:0]       quart;
    logic [eur_pkg::RECIP_PROD_BITS-1:0]  recip_prod;
    logic [eur_pkg::QUART_BITS-1:0]       quot;
    logic [eur_pkg::QUART_BITS-1:0]       lo_clamped;
    logic [eur_pkg::QUART_BITS-1:0]       clamped;
    logic                                 trig;
    logic                                 busy;
    logic                                 done;

    // Distance = pulse * 17 / 100, divide done as (x >> 2) * recip(25).
    always_comb
    begin
        prod       = eur_pkg::PROD_BITS'(pulse_reg) * eur_pkg::DIST_MUL;
        quart      = prod[eur_pkg::PROD_BITS-1:2];
        recip_prod = eur_pkg::RECIP_PROD_BITS'(quart) *
                     eur_pkg::RECIP_PROD_BITS'(eur_pkg::DIST_RECIP);
        quot       = eur_pkg::QUART_BITS'(recip_prod >> eur_pkg::RECIP_SHIFT);
        lo_clamped = (quot < eur_pkg::QUART_BITS'(cfg.min_range_mm)) ?
                     eur_pkg::QUART_BITS'(cfg.min_range_mm) : quot;
        clamped    = (lo_clamped > eur_pkg::QUART_BITS'(cfg.max_range_mm)) ?
                     eur_pkg::QUART_BITS'(cfg.max_range_mm) : lo_clamped;
    end

    always_comb
    begin
        width      = (cfg.trigger_width_us == 8'd0) ? 16'd1 : {8'd0, cfg.trigger_width_us};
        cnt_inc    = cnt_reg + 16'd1;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        pulse_next = pulse_reg;
        dist_next  = dist_reg;
        stat_next  = stat_reg;
        trig       = 1'b0;
        busy       = 1'b1;
        done       = 1'b0;

        unique case (phase_reg)
            eur_pkg::PH_IDLE:
            begin
                if (item.start_req)
                begin
                    phase_next = eur_pkg::PH_TRIG_LOW;
                    cnt_next   = 16'd1;
                end
                else
                begin
                    busy = 1'b0;
                end
            end
            eur_pkg::PH_TRIG_LOW:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc >= eur_pkg::TRIG_LOW_TICKS)
                begin
                    phase_next = eur_pkg::PH_TRIG_HIGH;
                    cnt_next   = 16'd0;
                end
            end
            eur_pkg::PH_TRIG_HIGH:
            begin
                trig     = 1'b1;
                cnt_next = cnt_inc;
                if (cnt_inc >= width)
                begin
                    phase_next = eur_pkg::PH_WAIT;
                    cnt_next   = 16'd0;
                end
            end
            eur_pkg::PH_WAIT:
            begin
                if (item.echo_level)
                begin
                    if (cfg.timeout_us == 16'd0)
                    begin
                        pulse_next = '0;
                        done       = 1'b1;
                        stat_next  = eur_pkg::STATUS_TIMEOUT;
                        phase_next = eur_pkg::PH_IDLE;
                        cnt_next   = 16'd0;
                    end
                    else
                    begin
                        pulse_next = eur_pkg::PULSE_COUNT_BITS'(1);
                        phase_next = eur_pkg::PH_MEASURE;
                        cnt_next   = 16'd1;
                    end
                end
                else if (cnt_reg >= cfg.timeout_us)
                begin
                    done       = 1'b1;
                    stat_next  = eur_pkg::STATUS_TIMEOUT;
                    phase_next = eur_pkg::PH_IDLE;
                    cnt_next   = 16'd0;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            eur_pkg::PH_MEASURE:
            begin
                if (!item.echo_level)
                begin
                    done       = 1'b1;
                    stat_next  = eur_pkg::STATUS_OK;
                    dist_next  = clamped[15:0];
                    phase_next = eur_pkg::PH_IDLE;
                    cnt_next   = 16'd0;
                end
                else if (cnt_reg >= cfg.timeout_us)
                begin
                    done       = 1'b1;
                    stat_next  = eur_pkg::STATUS_TIMEOUT;
                    phase_next = eur_pkg::PH_IDLE;
                    cnt_next   = 16'd0;
                end
                else
                begin
                    cnt_next = cnt_inc;
                    // saturate the pulse count
                    if (pulse_reg != eur_pkg::PULSE_MAX)
                    begin
                        pulse_next = pulse_reg + eur_pkg::PULSE_COUNT_BITS'(1);
                    end
                end
            end
            default:
            begin
                phase_next = eur_pkg::PH_IDLE;
                cnt_next   = 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= eur_pkg::PH_IDLE;
            cnt_reg   <= 16'd0;
            pulse_reg <= '0;
            dist_reg  <= 16'd0;
            stat_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            pulse_reg <= pulse_next;
            dist_reg  <= dist_next;
            stat_reg  <= stat_next;
        end
    end

    always_comb
    begin
        result.trigger_level = trig;
        result.busy_res      = busy;
        result.done_res      = done;
        result.status        = stat_next;
        result.range_mm      = dist_next;
    end

endmodule

`default_nettype wire

>>> tb/ultrasonic_echo_ranger_unit_tb.sv
module ultrasonic_echo_ranger_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 500_000;
    localparam int RAND_ITEMS   = 700;
    localparam int HOLD_CYCLES  = 64;
    localparam int DIR_LEN      = 23;
    localparam logic [31:0] RANGE_MUL = 32'd17;
    localparam logic [31:0] RANGE_DIV = 32'd100;

    typedef struct packed {
        logic               start_req;
        logic               echo_level;
        logic               typed;
        eur_pkg::out_word_t want;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    eur_pkg::in_word_t  in_word;
    logic               out_valid;
    logic               out_stall;
    eur_pkg::out_word_t out_word;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [eur_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [15:0] cfg_data;

    // ranger state as seen by the testbench
    eur_pkg::cfg_t   regs;
    eur_pkg::phase_t ph_now;
    logic [15:0] ph_ticks;
    logic [eur_pkg::PULSE_COUNT_BITS-1:0] echo_ticks;
    logic [15:0] last_mm;
    logic        last_st;

    eur_pkg::out_word_t tick_reports_q[$];
    int        errors = 0;
    int        results_seen = 0;
    int        items_sent = 0;
    int        cycles = 0;
    bit        send_gaps = 1'b1;
    bit        pressure_done = 1'b0;

    // start, echo, typed, trigger, busy, done, status, distance
    dir_row_t dir_rows [DIR_LEN] = '{
        {1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, eur_pkg::STATUS_OK,      16'd0},
        {1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, eur_pkg::STATUS_OK,      16'd0},
        {1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, eur_pkg::STATUS_OK,      16'd0},
        {1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, eur_pkg::STATUS_OK,      16'd0},
        {1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, eur_pkg::STATUS_OK,      16'd0},
        {1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, eur_pkg::STATUS_OK,      16'd0},
        {1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, eur_pkg::STATUS_OK,      16'd0},
        {1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, eur_pkg::STATUS_OK,      16'd0},
        // echo too long, and a start on the done tick
        {1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, eur_pkg::STATUS_TIMEOUT, 16'd0},
        {1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, eur_pkg::STATUS_TIMEOUT, 16'd0},
        {1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, eur_pkg::STATUS_OK,      16'd0},
        {1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, eur_pkg::STATUS_OK,      16'd0},
        {1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, eur_pkg::STATUS_OK,      16'd0},
        {1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, eur_pkg::STATUS_OK,      16'd0},
        {1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, eur_pkg::STATUS_OK,      16'd0},
        {1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, eur_pkg::STATUS_OK,      16'd0},
        {1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, eur_pkg::STATUS_OK,      16'd0},
        {1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, eur_pkg::STATUS_OK,      16'd0},
        {1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, eur_pkg::STATUS_OK,      16'd0},
        {1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, eur_pkg::STATUS_OK,      16'd0},
        {1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, eur_pkg::STATUS_OK,      16'd0},
        // no echo at all
        {1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, eur_pkg::STATUS_TIMEOUT, 16'd0},
        {1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, eur_pkg::STATUS_TIMEOUT, 16'd0}
    };

    ultrasonic_echo_ranger_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void reset_ranger();
        regs.trigger_width_us = 8'd12;
        regs.timeout_us       = 16'd30000;
        regs.min_range_mm     = 16'd20;
        regs.max_range_mm     = 16'd4000;
        ph_now     = eur_pkg::PH_IDLE;
        ph_ticks   = '0;
        echo_ticks = '0;
        last_mm    = '0;
        last_st    = eur_pkg::STATUS_OK;
    endfunction

    function automatic void close_measure(logic st);
        logic [31:0] mm;
        if (st == eur_pkg::STATUS_OK)
        begin
            mm = 32'(echo_ticks) * RANGE_MUL / RANGE_DIV;
            if (mm < 32'(regs.min_range_mm))
                mm = 32'(regs.min_range_mm);
            // max wins over min
            if (mm > 32'(regs.max_range_mm))
                mm = 32'(regs.max_range_mm);
            last_mm = mm[15:0];
        end
        last_st  = st;
        ph_now   = eur_pkg::PH_IDLE;
        ph_ticks = '0;
    endfunction

    function automatic eur_pkg::out_word_t step_ranger(eur_pkg::in_word_t w);
        eur_pkg::out_word_t r;
        logic [15:0]        hi_len;
        r = '0;
        r.busy_res = 1'b1;
        hi_len = (regs.trigger_width_us == 8'd0) ? 16'd1 : 16'(regs.trigger_width_us);
        case (ph_now)
            eur_pkg::PH_IDLE:
            begin
                if (w.start_req)
                begin
                    ph_now   = eur_pkg::PH_TRIG_LOW;
                    ph_ticks = 16'd1;
                end
                else
                    r.busy_res = 1'b0;
            end
            eur_pkg::PH_TRIG_LOW:
            begin
                ph_ticks = ph_ticks + 16'd1;
                if (ph_ticks >= eur_pkg::TRIG_LOW_TICKS)
                begin
                    ph_now   = eur_pkg::PH_TRIG_HIGH;
                    ph_ticks = '0;
                end
            end
            eur_pkg::PH_TRIG_HIGH:
            begin
                r.trigger_level = 1'b1;
                ph_ticks = ph_ticks + 16'd1;
                if (ph_ticks >= hi_len)
                begin
                    ph_now   = eur_pkg::PH_WAIT;
                    ph_ticks = '0;
                end
            end
            eur_pkg::PH_WAIT:
            begin
                if (w.echo_level)
                begin
                    echo_ticks = '0;
                    if (regs.timeout_us == 16'd0)
                    begin
                        r.done_res = 1'b1;
                        close_measure(eur_pkg::STATUS_TIMEOUT);
                    end
                    else
                    begin
                        echo_ticks = eur_pkg::PULSE_COUNT_BITS'(1);
                        ph_now     = eur_pkg::PH_MEASURE;
                        ph_ticks   = 16'd1;
                    end
                end
                else if (ph_ticks >= regs.timeout_us)
                begin
                    r.done_res = 1'b1;
                    close_measure(eur_pkg::STATUS_TIMEOUT);
                end
                else
                    ph_ticks = ph_ticks + 16'd1;
            end
            default:
            begin
                if (!w.echo_level)
                begin
                    r.done_res = 1'b1;
                    close_measure(eur_pkg::STATUS_OK);
                end
                else if (ph_ticks >= regs.timeout_us)
                begin
                    r.done_res = 1'b1;
                    close_measure(eur_pkg::STATUS_TIMEOUT);
                end
                else
                begin
                    ph_ticks = ph_ticks + 16'd1;
                    if (echo_ticks != eur_pkg::PULSE_MAX)
                        echo_ticks = echo_ticks + 1'b1;
                end
            end
        endcase
        r.status   = last_st;
        r.range_mm = last_mm;
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic stray_start();
        return ($urandom_range(0, 7) == 0);
    endfunction

    task automatic send_tick(logic start, logic echo, bit typed, eur_pkg::out_word_t want);
        int                 g;
        eur_pkg::in_word_t  w;
        eur_pkg::out_word_t predicted;
        w.start_req  = start;
        w.echo_level = echo;
        @(negedge clk);
        g = send_gaps ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid = 1'b0;
            repeat (g) @(negedge clk);
        end
        in_word  = w;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        predicted = step_ranger(w);
        tick_reports_q.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic write_reg(logic [eur_pkg::CFG_INDEX_BITS-1:0] idx, logic [15:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            eur_pkg::CFG_TRIGGER_WIDTH: regs.trigger_width_us = data[7:0];
            eur_pkg::CFG_TIMEOUT:       regs.timeout_us       = data;
            eur_pkg::CFG_MIN_DISTANCE:  regs.min_range_mm     = data;
            eur_pkg::CFG_MAX_DISTANCE:  regs.max_range_mm     = data;
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [7:0] width, logic [15:0] tmo,
                                 logic [15:0] lo_mm, logic [15:0] hi_mm);
        // junk in the upper byte of the width word must be dropped
        write_reg(eur_pkg::CFG_TRIGGER_WIDTH, {8'($urandom), width});
        write_reg(eur_pkg::CFG_TIMEOUT, tmo);
        write_reg(eur_pkg::CFG_MIN_DISTANCE, lo_mm);
        write_reg(eur_pkg::CFG_MAX_DISTANCE, hi_mm);
        write_reg(8'($urandom_range(4, 255)), 16'($urandom));
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (tick_reports_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_measurement();
        int hi_len;
        int cap;
        int lows;
        int highs;
        hi_len = (regs.trigger_width_us == 8'd0) ? 1 : int'(regs.trigger_width_us);
        cap    = int'(regs.timeout_us) + 1;
        // timeout + 1 low or high samples end the measurement with a timeout
        lows   = $urandom_range(0, (cap < 60) ? cap : 60);
        highs  = $urandom_range(1, (cap < 80) ? cap : 80);
        send_tick(1'b1, 1'($urandom_range(0, 1)), 1'b0, '0);
        repeat (1 + hi_len) send_tick(stray_start(), 1'($urandom_range(0, 1)), 1'b0, '0);
        repeat (lows) send_tick(stray_start(), 1'b0, 1'b0, '0);
        repeat (highs) send_tick(stray_start(), 1'b1, 1'b0, '0);
        send_tick(stray_start(), 1'b0, 1'b0, '0);
    endtask

    initial
    begin
        int ph;
        int budget;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        reset_ranger();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        load_settings(8'd0, 16'd2, 16'd0, 16'hFFFF);
        foreach (dir_rows[i])
            send_tick(dir_rows[i].start_req, dir_rows[i].echo_level,
                      dir_rows[i].typed, dir_rows[i].want);

        items_sent = 0;
        ph = 0;
        while (ph < 5 || items_sent < RAND_ITEMS)
        begin
            drain();
            case (ph)
                0: load_settings(8'd255, 16'd40, 16'd0, 16'hFFFF);
                1: load_settings(8'd1, 16'd1, 16'd0, 16'hFFFF);
                2: load_settings(8'd0, 16'd0, 16'd20, 16'd4000);
                3: load_settings(8'd3, 16'd30, 16'd100, 16'd10);
                4: load_settings(8'd2, 16'hFFFF, 16'd5, 16'd9);
                default: load_settings(8'($urandom_range(0, 8)), 16'($urandom_range(0, 40)),
                                       16'($urandom_range(0, 12)),
                                       ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                                   : 16'($urandom_range(0, 15)));
            endcase
            send_gaps = ($urandom_range(0, 2) != 0);
            // the widest trigger makes one measurement long enough
            budget = items_sent + ((ph == 0) ? 1 : 70);
            while (items_sent < budget)
            begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 8))
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'b0, '0);
                else
                    run_measurement();
            end
            ph++;
        end

        drain();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("ultrasonic_echo_ranger_unit_tb: PASS");
        else
            $display("ultrasonic_echo_ranger_unit_tb: FAIL");
        $finish;
    end

    initial
    begin
        int n;
        int quiet;
        quiet     = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!pressure_done && results_seen >= 150 && in_valid)
            begin
                // hold off long enough to back up into the input side
                pressure_done = 1'b1;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (quiet > 0)
            begin
                quiet--;
                out_stall = 1'b0;
            end
            else
            begin
                n = gap_len();
                if (n == 0)
                begin
                    out_stall = 1'b0;
                    if ($urandom_range(0, 39) == 0)
                        quiet = $urandom_range(20, 80);
                end
                else
                begin
                    out_stall = 1'b1;
                    repeat (n - 1) @(negedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_reports
        eur_pkg::out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (tick_reports_q.size() == 0)
            begin
                $error("unexpected word: %h", out_word);
                errors++;
            end
            else
            begin
                want = tick_reports_q.pop_front();
                if (out_word.trigger_level !== want.trigger_level)
                begin
                    $error("trigger_level: expected %0d, got %0d",
                           want.trigger_level, out_word.trigger_level);
                    errors++;
                end
                if (out_word.busy_res !== want.busy_res)
                begin
                    $error("busy_res: expected %0d, got %0d", want.busy_res, out_word.busy_res);
                    errors++;
                end
                if (out_word.done_res !== want.done_res)
                begin
                    $error("done_res: expected %0d, got %0d", want.done_res, out_word.done_res);
                    errors++;
                end
                if (out_word.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, out_word.status);
                    errors++;
                end
                if (out_word.range_mm !== want.range_mm)
                begin
                    $error("range_mm: expected %0d, got %0d",
                           want.range_mm, out_word.range_mm);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("ultrasonic_echo_ranger_unit_tb: FAIL");
            $finish;
        end
    end

endmodule
